// ----- rtl/slsdm_pkg.sv -----
package slsdm_pkg;

    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [2:0] {
        SZ_BYTE   = 3'd0,
        SZ_HALF   = 3'd1,
        SZ_WORD   = 3'd2,
        SZ_BYTE_U = 3'd4,
        SZ_HALF_U = 3'd5
    } t_size_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_ACCESS,
        ST_DONE
    } t_state;

    // Byte count of a size code; zero marks an invalid code.
    function automatic logic [2:0] size_bytes(input logic [2:0] code);
        logic [2:0] cnt;
        case (code)
            SZ_BYTE, SZ_BYTE_U: cnt = 3'd1;
            SZ_HALF, SZ_HALF_U: cnt = 3'd2;
            SZ_WORD:            cnt = 3'd4;
            default:            cnt = 3'd0;
        endcase
        return cnt;
    endfunction

endpackage

// ----- rtl/slsdm_ram.sv -----
module slsdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/slsdm_addr_mod.sv -----
module slsdm_addr_mod #(
    parameter int MEM_BYTES = 32768
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_start,
    input  logic [slsdm_pkg::ADDR_W-1:0]                     i_address,
    output logic                                             o_done,
    output logic [((MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1)-1:0] o_rem
);

    import slsdm_pkg::*;

    localparam int  AW       = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam bit  IS_POW2  = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);

    logic [AW-1:0] r_rem;
    logic          r_done;

    if (IS_POW2) begin : g_mask
        // Power of two: the remainder is the low address bits.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_rem <= i_address[AW-1:0];
            end
        end
    end else begin : g_recip
        // Reciprocal multiplication: q = (address * RECIP) >> 32 is the true quotient or one
        // below it, so address - q * MEM_BYTES lies in [0, 2 * MEM_BYTES) and one subtract
        // finishes. Only the low AW+1 bits of the difference are needed.
        localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(MEM_BYTES));
        localparam logic [AW:0] MODULUS = (AW+1)'(MEM_BYTES);

        logic [63:0] prod;
        logic [AW:0] r_alo;
        logic [AW:0] r_qlo;
        logic [AW:0] r_diff;
        logic        r_v1;
        logic        r_v2;

        assign prod = 64'(i_address) * 64'(RECIP);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1   <= 1'b0;
                r_v2   <= 1'b0;
                r_done <= 1'b0;
            end else begin
                r_v1   <= i_start;
                r_v2   <= r_v1;
                r_done <= r_v2;
            end
            if (i_start) begin
                r_alo <= i_address[AW:0];
                r_qlo <= prod[32 +: AW+1];
            end
            if (r_v1) begin
                r_diff <= r_alo - r_qlo * MODULUS;
            end
            if (r_v2) begin
                r_rem <= (r_diff >= MODULUS) ? AW'(r_diff - MODULUS) : r_diff[AW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/sized_load_store_data_memory.sv -----
// Sequence: an accepted request waits in ST_ADDR while its start address is reduced modulo
// MEM_BYTES (low-bit masking for a power of two, pipelined reciprocal reduction otherwise),
// moves N = 1, 2 or 4 bytes in ST_ACCESS and loads its result from ST_DONE; an invalid size
// code goes straight to ST_DONE. Requests are taken only in ST_IDLE, one at a time;
// the byte-wide memory port moves one byte per cycle and a stalled result holds requests.
// Reset (synchronous, active low) clears control state only; memory contents stay undefined.
module sized_load_store_data_memory #(
    parameter int MEM_BYTES = 32768
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_mode,
    input  logic [2:0]                   i_size_op,
    input  logic [slsdm_pkg::ADDR_W-1:0] i_address,
    input  logic [slsdm_pkg::DATA_W-1:0] i_write_data,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [slsdm_pkg::DATA_W-1:0] o_read_data,
    output logic                         o_bad_size
);

    import slsdm_pkg::*;

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    // FSM and request registers
    t_state            r_state, n_state;
    logic              r_mode;
    t_size_op          r_size;
    logic              r_bad;
    logic [DATA_W-1:0] r_wdata;
    logic [AW-1:0]     r_idx;
    logic [2:0]        r_left;
    logic [1:0]        r_lane;

    // read return tracking
    logic              r_rd_pending;
    logic [1:0]        r_rd_lane;
    logic [DATA_W-1:0] r_acc;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_bad;

    logic              req_accept;
    logic              out_take;
    logic              out_load;
    logic              mod_start;
    logic              mod_done;
    logic [AW-1:0]     mod_rem;
    logic              ram_en;
    logic [7:0]        ram_rdata;
    logic [AW-1:0]     idx_next;
    logic [DATA_W-1:0] acc_now;
    logic [DATA_W-1:0] result;
    logic [2:0]        req_bytes;

    assign req_accept = i_valid && !o_stall;
    assign out_take   = r_out_valid && !i_stall;
    assign req_bytes  = size_bytes(i_size_op);

    // Reduce the start address modulo the memory size; the address is taken straight
    // from the port in the accept cycle.
    slsdm_addr_mod #(
        .MEM_BYTES (MEM_BYTES)
    ) u_addr_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_address (i_address),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    // Byte store: one byte read or written per cycle.
    slsdm_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (r_mode == MODE_WRITE),
        .i_addr  (r_idx),
        .i_wdata (r_wdata[7:0]),
        .o_rdata (ram_rdata)
    );

    // Wrap each following byte address back to entry 0 past the end.
    assign idx_next = (r_idx == AW'(MEM_BYTES - 1)) ? '0 : r_idx + 1'b1;

    // Merge the byte that returns this cycle into the accumulated value.
    assign acc_now = r_rd_pending ? (r_acc | (DATA_W'(ram_rdata) << {r_rd_lane, 3'b000}))
                                  : r_acc;

    // Extend the assembled value; writes and invalid codes return zero.
    always_comb begin
        result = acc_now;
        if (r_bad || r_mode == MODE_WRITE) begin
            result = '0;
        end else if (r_size == SZ_BYTE && acc_now[7]) begin
            result = acc_now | 32'hFFFF_FF00;
        end else if (r_size == SZ_HALF && acc_now[15]) begin
            result = acc_now | 32'hFFFF_0000;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state   = r_state;
        o_stall   = 1'b1;
        mod_start = 1'b0;
        ram_en    = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (req_bytes == 3'd0) begin
                        n_state = ST_DONE;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = ST_ADDR;
                    end
                end
            end
            ST_ADDR: begin
                if (mod_done) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                ram_en = 1'b1;
                if (r_left == 3'd1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rd_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_pending <= ram_en && (r_mode == MODE_READ);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and byte sequencing
    always_ff @(posedge i_clk) begin
        r_rd_lane <= r_lane;
        if (req_accept) begin
            r_mode  <= i_mode;
            r_size  <= t_size_op'(i_size_op);
            r_bad   <= (req_bytes == 3'd0);
            r_wdata <= i_write_data;
            r_left  <= req_bytes;
            r_lane  <= '0;
            r_acc   <= '0;
        end else begin
            r_acc   <= acc_now;
        end
        if (r_state == ST_ADDR && mod_done) begin
            r_idx <= mod_rem;
        end
        if (ram_en) begin
            // Advance to the next byte and lane.
            r_idx   <= idx_next;
            r_wdata <= r_wdata >> 8;
            r_left  <= r_left - 1'b1;
            r_lane  <= r_lane + 1'b1;
        end
        if (out_load) begin
            r_out_data <= result;
            r_out_bad  <= r_bad;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_bad_size  = r_out_bad;

endmodule

// ----- rtl/slsdm_checker.sv -----
module slsdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_read_data,
    input logic        o_bad_size
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // One request at a time: an accepted request blocks the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request channel open right after accept");

    // A new result appears only after a request was in work.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a request in work");

    // An invalid size code never returns data.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_size |-> o_read_data == 32'd0)
        else $error("invalid size code returned data");

endmodule

bind sized_load_store_data_memory slsdm_checker u_slsdm_checker (.*);
